[rtl/diff_drive_odometry_macros.svh]
// Assertion macros for the differential drive odometry block.
// Used by the top level only; expects clk and rst in scope.
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ddo_pkg.sv]
// Shared types, constants and tables for the odometry block.
// No dependencies; used by ddo_ctrl, ddo_datapath and diff_drive_odometry.
`default_nettype none

package ddo_pkg;

  typedef struct packed {
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
    logic               moving_forward;
  } in_req_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [47:0] travelled;
    logic signed [31:0] speed;
  } out_res_t;

  typedef enum logic [1:0] {
    CFG_MM_PER_TICK   = 2'd0,
    CFG_TURN_PER_TICK = 2'd1,
    CFG_LOOP_FREQ_HZ  = 2'd2
  } cfg_idx_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [23:0] MM_PER_TICK_RST   = 24'd65536;
  localparam logic [31:0] TURN_PER_TICK_RST = 32'd65536;
  localparam logic [15:0] LOOP_FREQ_RST     = 16'd1000;

  localparam logic [32:0] CORR_K      = 33'd1766234505;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

  // speed averaging window, a power of two so the average is a shift
  localparam int SPEED_WINDOW = 16;
  localparam int WIN_SHIFT    = $clog2(SPEED_WINDOW);

  localparam int STEP_W   = 5;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_M_TRANS, OP_M_HALF, OP_CAP_HALF, OP_M_UU, OP_M_QK,
    OP_M_SAMPLE, OP_CAP_SAMPLE, OP_WIN, OP_CORDIC, OP_CFIX,
    OP_M_TC, OP_CAP_TC, OP_M_X, OP_M_Y, OP_CAP_Y
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M_TRANS, ST_M_HALF, ST_CAP_HALF, ST_M_UU, ST_M_QK,
    ST_M_SAMPLE, ST_CAP_SAMPLE, ST_WIN, ST_CORDIC, ST_CFIX,
    ST_M_TC, ST_CAP_TC, ST_M_X, ST_M_Y, ST_CAP_Y, ST_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } cmd_t;

  // atan(2^-i) in turns * 2^32
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] a;
    unique case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      5'd30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sh0_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -50'sh0_8000_0000_0000) r = 48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ddo_ctrl.sv]
// Sequencer for the odometry datapath: state machine and iteration counter.
// Depends on ddo_pkg.
`default_nettype none

module ddo_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  output ddo_pkg::cmd_t      cmd
);

  localparam logic [ddo_pkg::STEP_W-1:0] CORDIC_LAST = ddo_pkg::STEP_W'(CORDIC_STEPS - 1);

  ddo_pkg::state_t state, state_next;
  logic [ddo_pkg::STEP_W-1:0] step, step_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ddo_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = '0;
    in_ready     = 1'b0;
    cmd.op       = ddo_pkg::OP_NONE;
    cmd.step     = step;
    cmd.load_out = 1'b0;
    unique case (state)
      ddo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = ddo_pkg::OP_LOAD;
          state_next = ddo_pkg::ST_M_TRANS;
        end
      end
      ddo_pkg::ST_M_TRANS: begin
        cmd.op = ddo_pkg::OP_M_TRANS; state_next = ddo_pkg::ST_M_HALF;
      end
      ddo_pkg::ST_M_HALF: begin
        cmd.op = ddo_pkg::OP_M_HALF; state_next = ddo_pkg::ST_CAP_HALF;
      end
      ddo_pkg::ST_CAP_HALF: begin
        cmd.op = ddo_pkg::OP_CAP_HALF; state_next = ddo_pkg::ST_M_UU;
      end
      ddo_pkg::ST_M_UU: begin
        cmd.op = ddo_pkg::OP_M_UU; state_next = ddo_pkg::ST_M_QK;
      end
      ddo_pkg::ST_M_QK: begin
        cmd.op = ddo_pkg::OP_M_QK; state_next = ddo_pkg::ST_M_SAMPLE;
      end
      ddo_pkg::ST_M_SAMPLE: begin
        cmd.op = ddo_pkg::OP_M_SAMPLE; state_next = ddo_pkg::ST_CAP_SAMPLE;
      end
      ddo_pkg::ST_CAP_SAMPLE: begin
        cmd.op = ddo_pkg::OP_CAP_SAMPLE; state_next = ddo_pkg::ST_WIN;
      end
      ddo_pkg::ST_WIN: begin
        cmd.op = ddo_pkg::OP_WIN; state_next = ddo_pkg::ST_CORDIC;
      end
      ddo_pkg::ST_CORDIC: begin
        cmd.op = ddo_pkg::OP_CORDIC;
        if (step == CORDIC_LAST) state_next = ddo_pkg::ST_CFIX;
        else step_next = step + 1'b1;
      end
      ddo_pkg::ST_CFIX: begin
        cmd.op = ddo_pkg::OP_CFIX; state_next = ddo_pkg::ST_M_TC;
      end
      ddo_pkg::ST_M_TC: begin
        cmd.op = ddo_pkg::OP_M_TC; state_next = ddo_pkg::ST_CAP_TC;
      end
      ddo_pkg::ST_CAP_TC: begin
        cmd.op = ddo_pkg::OP_CAP_TC; state_next = ddo_pkg::ST_M_X;
      end
      ddo_pkg::ST_M_X: begin
        cmd.op = ddo_pkg::OP_M_X; state_next = ddo_pkg::ST_M_Y;
      end
      ddo_pkg::ST_M_Y: begin
        cmd.op = ddo_pkg::OP_M_Y; state_next = ddo_pkg::ST_CAP_Y;
      end
      ddo_pkg::ST_CAP_Y: begin
        cmd.op = ddo_pkg::OP_CAP_Y; state_next = ddo_pkg::ST_DONE;
      end
      ddo_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ddo_pkg::ST_IDLE;
        end
      end
      default: state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

`default_nettype wire

[rtl/ddo_datapath.sv]
// Odometry datapath: config registers, shared multiplier, CORDIC, speed window
// and output register. Depends on ddo_pkg; driven by ddo_ctrl.
`default_nettype none

module ddo_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ddo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ddo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire ddo_pkg::in_req_t                    in_data,
  input  wire ddo_pkg::cmd_t                       cmd,
  output ddo_pkg::out_res_t                        out_data
);

  localparam int PW  = ddo_pkg::WIN_SHIFT;
  localparam logic [PW-1:0] POS_LAST = PW'(ddo_pkg::SPEED_WINDOW - 1);

  // configuration
  logic [23:0] mm_per_tick;
  logic [31:0] turn_per_tick;
  logic [15:0] loop_freq_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_per_tick   <= ddo_pkg::MM_PER_TICK_RST;
      turn_per_tick <= ddo_pkg::TURN_PER_TICK_RST;
      loop_freq_hz  <= ddo_pkg::LOOP_FREQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddo_pkg::CFG_MM_PER_TICK:   mm_per_tick   <= cfg_data[23:0];
        ddo_pkg::CFG_TURN_PER_TICK: turn_per_tick <= cfg_data;
        ddo_pkg::CFG_LOOP_FREQ_HZ:  loop_freq_hz  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic signed [16:0] sum, diff;
  logic               fwd;
  logic signed [32:0] trans, corr;
  logic signed [46:0] half;
  logic        [31:0] mid;
  logic signed [31:0] sample;
  logic signed [33:0] tc;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic               flip;
  logic        [39:0] dq;
  logic               dneg;

  // state
  logic signed [47:0] x_acc, y_acc, distance_acc;
  logic        [31:0] heading_acc;
  logic signed [39:0] window_sum;
  logic        [PW-1:0] window_pos;
  logic [ddo_pkg::SPEED_WINDOW-1:0] win_valid;
  logic        [31:0] win_mem [ddo_pkg::SPEED_WINDOW];
  logic        [31:0] win_rd;
  logic               win_rd_v;

  // shared multiplier
  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [67:0] prod;

  logic [46:0] hm;
  logic [23:0] u;

  always_comb begin
    hm = half[46] ? 47'(-half) : 47'(half);
    u  = (hm > 47'd2147483648) ? 24'd8388608 : hm[31:8];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      ddo_pkg::OP_M_TRANS: begin mul_a = 35'(sum);  mul_b = {9'd0, mm_per_tick}; end
      ddo_pkg::OP_M_HALF:  begin mul_a = 35'(diff); mul_b = {1'b0, turn_per_tick}; end
      ddo_pkg::OP_M_UU:    begin mul_a = {11'd0, u}; mul_b = {9'd0, u}; end
      ddo_pkg::OP_M_QK:    begin mul_a = {6'd0, prod[46:18]}; mul_b = ddo_pkg::CORR_K; end
      ddo_pkg::OP_M_SAMPLE: begin mul_a = 35'(trans); mul_b = {17'd0, loop_freq_hz}; end
      ddo_pkg::OP_M_TC:    begin mul_a = 35'(trans); mul_b = corr; end
      ddo_pkg::OP_M_X:     begin mul_a = 35'(tc); mul_b = cx[32:0]; end
      ddo_pkg::OP_M_Y:     begin mul_a = 35'(tc); mul_b = cy[32:0]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // rounding and combinational helpers
  logic signed [67:0] prod_r256, prod_r2, prod_r128, prod_r29;
  logic signed [40:0] samp_w;
  logic signed [37:0] dprod;
  logic signed [32:0] z_ang, z_init;
  logic               flip_init;
  logic signed [33:0] xs, ys;
  logic        [4:0]  cidx;
  logic        [31:0] old_samp;
  logic signed [39:0] ws_new;

  always_comb begin
    prod_r256 = prod + 68'sd256;
    prod_r2   = prod + 68'sd2;
    prod_r128 = prod + 68'sd128;
    prod_r29  = prod + 68'sd536870912;
    samp_w    = $signed(prod_r128[48:8]);
    dprod     = $signed(prod_r29[67:30]);
    z_ang     = 33'($signed(mid));
    z_init    = z_ang;
    flip_init = 1'b0;
    if (z_ang > 33'sd1073741824) begin
      z_init = z_ang - 33'sd2147483648; flip_init = 1'b1;
    end else if (z_ang < -33'sd1073741824) begin
      z_init = z_ang + 33'sd2147483648; flip_init = 1'b1;
    end
    cidx     = cmd.step;
    xs       = cx >>> cidx;
    ys       = cy >>> cidx;
    old_samp = win_rd_v ? win_rd : 32'd0;
    ws_new   = window_sum - 40'($signed(old_samp)) + 40'(sample);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ddo_pkg::OP_LOAD: begin
        sum  <= 17'(in_data.left_ticks) + 17'(in_data.right_ticks);
        diff <= 17'(in_data.right_ticks) - 17'(in_data.left_ticks);
        fwd  <= in_data.moving_forward;
      end
      ddo_pkg::OP_M_HALF:   trans <= $signed(prod_r256[41:9]);
      ddo_pkg::OP_CAP_HALF: half <= $signed(prod_r2[48:2]);
      ddo_pkg::OP_M_UU:     mid <= heading_acc + half[31:0];
      ddo_pkg::OP_M_QK: begin
        cx   <= $signed(ddo_pkg::CORDIC_GAIN);
        cy   <= '0;
        cz   <= z_init;
        flip <= flip_init;
      end
      ddo_pkg::OP_M_SAMPLE: corr <= 33'sd1073741824 - $signed({1'b0, prod[59:28]});
      ddo_pkg::OP_CAP_SAMPLE: begin
        if (samp_w > 41'sd2147483647) sample <= 32'sh7FFF_FFFF;
        else if (samp_w < -41'sd2147483648) sample <= 32'sh8000_0000;
        else sample <= samp_w[31:0];
      end
      ddo_pkg::OP_WIN: begin
        dneg <= ws_new[39];
        dq   <= ws_new[39] ? 40'(-ws_new) : 40'(ws_new);
      end
      ddo_pkg::OP_CORDIC: begin
        if (!cz[32]) begin
          cx <= cx - ys; cy <= cy + xs; cz <= cz - $signed({3'd0, ddo_pkg::atan_turn(cidx)});
        end else begin
          cx <= cx + ys; cy <= cy - xs; cz <= cz + $signed({3'd0, ddo_pkg::atan_turn(cidx)});
        end
      end
      ddo_pkg::OP_CFIX: begin
        if (flip) begin
          cx <= -cx; cy <= -cy;
        end
      end
      ddo_pkg::OP_CAP_TC: tc <= $signed(prod_r29[63:30]);
      default: ;
    endcase
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc        <= '0;
      y_acc        <= '0;
      distance_acc <= '0;
      heading_acc  <= '0;
      window_sum   <= '0;
      window_pos   <= '0;
      win_valid    <= '0;
    end else begin
      case (cmd.op)
        ddo_pkg::OP_M_UU: heading_acc <= heading_acc + {half[30:0], 1'b0};
        ddo_pkg::OP_WIN: begin
          window_sum <= ws_new;
          win_valid[window_pos] <= 1'b1;
          window_pos <= (window_pos == POS_LAST) ? '0 : window_pos + 1'b1;
          distance_acc <= ddo_pkg::sat48(fwd ? 50'(distance_acc) + 50'(trans)
                                             : 50'(distance_acc) - 50'(trans));
        end
        ddo_pkg::OP_M_Y:   x_acc <= ddo_pkg::sat48(50'(x_acc) + 50'(dprod));
        ddo_pkg::OP_CAP_Y: y_acc <= ddo_pkg::sat48(50'(y_acc) + 50'(dprod));
        default: ;
      endcase
    end
  end

  // speed window memory
  always_ff @(posedge clk) begin
    if (cmd.op == ddo_pkg::OP_M_SAMPLE) begin
      win_rd   <= win_mem[window_pos];
      win_rd_v <= win_valid[window_pos];
    end
    if (cmd.op == ddo_pkg::OP_WIN) win_mem[window_pos] <= sample;
  end

  // result register; average truncates toward zero
  logic [39:0] spd;

  always_comb begin
    spd = dneg ? 40'(-(dq >> ddo_pkg::WIN_SHIFT)) : (dq >> ddo_pkg::WIN_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.pos_x     <= x_acc;
      out_data.pos_y     <= y_acc;
      out_data.heading   <= heading_acc;
      out_data.travelled <= distance_acc;
      out_data.speed     <= $signed(spd[31:0]);
    end
  end

endmodule

`default_nettype wire

[rtl/diff_drive_odometry.sv]
// Differential drive odometry: one pose update per request.
// Top level; instantiates ddo_ctrl and ddo_datapath, uses ddo_pkg and the macro header.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): left and right tick deltas plus direction.
//   out channel (out_valid/out_ready/out_data): pose, heading, travelled, speed.
//   cfg port (cfg_we/cfg_index/cfg_data): write only, change it while idle.
// One request is processed at a time through a shared 35x33 multiplier and an
// iterative CORDIC; the speed average over the window is a shift.
// From acceptance the sequencer steps through its states in order, with the
// CORDIC loop iterating CORDIC_STEPS times, and the result then goes to the
// output register; a new request is not taken until the last one is done.
// A new request is taken as soon as the sequencer returns to idle, even while
// the previous result is still held in the output register.
// If the receiver stalls, the finished result waits in the sequencer's last
// state until the output register is free; nothing is dropped.
// Reset clears pose, heading, distance, speed window and loads register defaults.
`default_nettype none
`include "diff_drive_odometry_macros.svh"

module diff_drive_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ddo_pkg::in_req_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ddo_pkg::out_res_t                   out_data
);

  ddo_pkg::cmd_t cmd;

  ddo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  ddo_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

  `DDO_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid || out_ready, "result overwritten")
  `DDO_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready && !cmd.load_out, "not busy")
  `DDO_ASSERT_NXT(a_valid_after_load, cmd.load_out, out_valid, "load without valid")
  `DDO_ASSERT_IMP(a_load_not_idle, in_ready, !cmd.load_out, "load while idle")

endmodule

`default_nettype wire

[tb/diff_drive_odometry_tb.sv]
// Testbench for diff_drive_odometry: directed table then random odometry requests.
// Pose, heading, distance and speed are predicted per request and checked in order.
// Depends on ddo_pkg and the diff_drive_odometry RTL.
`timescale 1ns / 1ps

module diff_drive_odometry_tb;

  localparam int WIN = ddo_pkg::SPEED_WINDOW;
  localparam int STEPS = 24;
  localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint MIN48 = -64'sh8000_0000_0000;
  localparam longint CYCLE_LIMIT = 64'd2000000;

  typedef struct {
    logic              wr_cfg;
    ddo_pkg::cfg_idx_t idx;
    logic [31:0]       val;
    ddo_pkg::in_req_t  req;
    logic              has_exp;
    ddo_pkg::out_res_t res;
  } row_t;

  logic clk, rst;
  logic cfg_we;
  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  ddo_pkg::in_req_t in_data;
  ddo_pkg::out_res_t out_data;

  diff_drive_odometry dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  longint mm_tick, turn_tick, freq;
  longint pos_x_acc, pos_y_acc, dist_acc, win_sum;
  logic [31:0] head_acc;
  longint win_slot[WIN];
  int win_idx;
  longint atan_tab[32];

  ddo_pkg::out_res_t pose_queue[$];
  int errors;
  longint cycles;
  int pending_total;
  bit done_sending;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > MAX48) return MAX48;
    if (v < MIN48) return MIN48;
    return v;
  endfunction

  task automatic cordic_rot(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'($signed(ang));
    flip = 0;
    x = 652032874;
    y = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic reset_pose();
    mm_tick = 65536; turn_tick = 65536; freq = 1000;
    pos_x_acc = 0; pos_y_acc = 0; dist_acc = 0; win_sum = 0;
    head_acc = 0; win_idx = 0;
    foreach (win_slot[i]) win_slot[i] = 0;
  endtask

  task automatic predict_pose(input ddo_pkg::in_req_t r, output ddo_pkg::out_res_t o);
    longint l, rt, trans, half, hm, u, q, corr, cs, sn, tc, sample;
    logic [31:0] mid;
    l = longint'(r.left_ticks);
    rt = longint'(r.right_ticks);
    trans = asr((l + rt) * mm_tick + 256, 9);
    half = asr((rt - l) * turn_tick + 2, 2);
    mid = head_acc + half[31:0];
    hm = half < 0 ? -half : half;
    head_acc = head_acc + 32'(2 * half);
    if (hm > 64'sd2147483648) hm = 64'sd2147483648;
    u = hm >>> 8;
    q = (u * u) >>> 18;
    corr = 64'sd1073741824 - ((q * 64'sd1766234505) >>> 28);
    cordic_rot(mid, cs, sn);
    tc = asr(trans * corr + 64'sd536870912, 30);
    pos_x_acc = clamp48(pos_x_acc + asr(tc * cs + 64'sd536870912, 30));
    pos_y_acc = clamp48(pos_y_acc + asr(tc * sn + 64'sd536870912, 30));
    dist_acc = clamp48(r.moving_forward ? dist_acc + trans : dist_acc - trans);
    sample = asr(trans * freq + 128, 8);
    if (sample > 64'sd2147483647) sample = 64'sd2147483647;
    if (sample < -64'sd2147483648) sample = -64'sd2147483648;
    win_sum = win_sum - win_slot[win_idx] + sample;
    win_slot[win_idx] = sample;
    win_idx = (win_idx + 1) % WIN;
    o.pos_x = pos_x_acc[47:0];
    o.pos_y = pos_y_acc[47:0];
    o.heading = head_acc;
    o.travelled = dist_acc[47:0];
    o.speed = 32'(win_sum / WIN);
  endtask

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // output side: random stall, check in order
  initial begin
    out_ready = 0;
    wait (!rst);
    forever begin
      int gap;
      ddo_pkg::out_res_t w;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pose_queue.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        w = pose_queue.pop_front();
        if (out_data.pos_x !== w.pos_x) report_mismatch("pos_x", out_data.pos_x, w.pos_x);
        if (out_data.pos_y !== w.pos_y) report_mismatch("pos_y", out_data.pos_y, w.pos_y);
        if (out_data.heading !== w.heading)
          report_mismatch("heading", 48'(out_data.heading), 48'(w.heading));
        if (out_data.travelled !== w.travelled)
          report_mismatch("travelled", out_data.travelled, w.travelled);
        if (out_data.speed !== w.speed)
          report_mismatch("speed", 48'(out_data.speed), 48'(w.speed));
      end
    end
  end

  task automatic write_reg(input ddo_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      ddo_pkg::CFG_MM_PER_TICK:   mm_tick = val[23:0];
      ddo_pkg::CFG_TURN_PER_TICK: turn_tick = val;
      ddo_pkg::CFG_LOOP_FREQ_HZ:  freq = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // hand one request over; expected result queued at acceptance
  task automatic send_req(input ddo_pkg::in_req_t r, input logic has_exp,
                          input ddo_pkg::out_res_t fixed);
    ddo_pkg::out_res_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pose(r, p);
    if (has_exp && p !== fixed) report_mismatch("table row", '0, '0);
    pose_queue.push_back(has_exp ? fixed : p);
  endtask

  function automatic ddo_pkg::in_req_t mk(int l, int r, bit f);
    ddo_pkg::in_req_t q;
    q.left_ticks = 16'(l);
    q.right_ticks = 16'(r);
    q.moving_forward = f;
    return q;
  endfunction

  function automatic row_t req_row(ddo_pkg::in_req_t q);
    row_t r;
    r.wr_cfg = 0; r.idx = ddo_pkg::CFG_MM_PER_TICK; r.val = 0; r.req = q;
    r.has_exp = 0; r.res = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(ddo_pkg::cfg_idx_t i, logic [31:0] v);
    row_t r;
    r = req_row('0);
    r.wr_cfg = 1; r.idx = i; r.val = v;
    return r;
  endfunction

  initial begin
    row_t tbl[$];
    row_t r0;
    ddo_pkg::out_res_t zero_res;
    atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
                 5, 3, 1, 1, 0};
    errors = 0; cycles = 0;
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_data = '0;
    reset_pose();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table
    zero_res = '0;
    r0 = req_row(mk(0, 0, 1)); r0.has_exp = 1; r0.res = zero_res;
    tbl.push_back(r0);
    // straight one tick each side at defaults: 1 mm forward (256 units of 1/256 mm), speed 1000/16
    r0 = req_row(mk(1, 1, 1)); r0.has_exp = 1;
    r0.res.pos_x = 48'sd256; r0.res.pos_y = 0; r0.res.heading = 0;
    r0.res.travelled = 48'sd256; r0.res.speed = 32'sd62;
    tbl.push_back(r0);
    tbl.push_back(req_row(mk(32767, 32767, 1)));
    tbl.push_back(req_row(mk(-32768, -32768, 0)));
    tbl.push_back(req_row(mk(-32768, 32767, 1)));
    tbl.push_back(req_row(mk(32767, -32768, 0)));
    tbl.push_back(req_row(mk(100, 300, 1)));
    tbl.push_back(cfg_row(ddo_pkg::CFG_TURN_PER_TICK, 32'hFFFF_FFFF));
    tbl.push_back(req_row(mk(-32768, 32767, 1)));
    tbl.push_back(req_row(mk(5, -7, 0)));
    tbl.push_back(cfg_row(ddo_pkg::CFG_MM_PER_TICK, 32'hFF_FFFF));
    tbl.push_back(cfg_row(ddo_pkg::CFG_LOOP_FREQ_HZ, 32'd65535));
    for (int i = 0; i < 8; i++) tbl.push_back(req_row(mk(32767, 32767, 1)));
    tbl.push_back(cfg_row(ddo_pkg::CFG_LOOP_FREQ_HZ, 32'd0));
    tbl.push_back(req_row(mk(1234, -321, 1)));
    tbl.push_back(cfg_row(ddo_pkg::CFG_MM_PER_TICK, 32'd0));
    tbl.push_back(cfg_row(ddo_pkg::CFG_TURN_PER_TICK, 32'd0));
    tbl.push_back(req_row(mk(-32768, 32767, 0)));

    foreach (tbl[i]) begin
      if (tbl[i].wr_cfg) begin
        drain();
        write_reg(tbl[i].idx, tbl[i].val);
      end else begin
        send_req(tbl[i].req, tbl[i].has_exp, tbl[i].res);
      end
    end

    // random phases with new settings
    for (int ph = 0; ph < 11; ph++) begin
      drain();
      case (ph % 4)
        0: begin
          write_reg(ddo_pkg::CFG_MM_PER_TICK, 32'd65536);
          write_reg(ddo_pkg::CFG_TURN_PER_TICK, 32'd65536);
          write_reg(ddo_pkg::CFG_LOOP_FREQ_HZ, 32'd1000);
        end
        1: begin
          write_reg(ddo_pkg::CFG_MM_PER_TICK, $urandom_range(0, 24'hFF_FFFF));
          write_reg(ddo_pkg::CFG_TURN_PER_TICK, $urandom);
          write_reg(ddo_pkg::CFG_LOOP_FREQ_HZ, $urandom_range(1, 65535));
        end
        2: begin
          write_reg(ddo_pkg::CFG_MM_PER_TICK, 32'hFF_FFFF);
          write_reg(ddo_pkg::CFG_TURN_PER_TICK, $urandom_range(0, 1 << 20));
          write_reg(ddo_pkg::CFG_LOOP_FREQ_HZ, 32'd65535);
        end
        default: begin
          write_reg(ddo_pkg::CFG_MM_PER_TICK, $urandom_range(0, 1 << 18));
          write_reg(ddo_pkg::CFG_TURN_PER_TICK, $urandom_range(0, 1 << 24));
          write_reg(ddo_pkg::CFG_LOOP_FREQ_HZ, $urandom_range(0, 2000));
        end
      endcase
      for (int k = 0; k < 48; k++) begin
        int l, rr;
        if ($urandom_range(0, 3) == 0) begin
          l = $signed(16'($urandom));
          rr = $signed(16'($urandom));
        end else begin
          l = $urandom_range(0, 400) - 200;
          rr = l + $urandom_range(0, 40) - 20;
        end
        send_req(mk(l, rr, 1'($urandom_range(0, 1))), 0, zero_res);
      end
    end

    in_valid <= 0;
    pending_total = 0;
    while (pose_queue.size() != 0 && pending_total < 200000) begin
      @(posedge clk);
      pending_total++;
    end
    repeat (120) @(posedge clk);
    if (errors == 0 && pose_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
